// ----- rtl/core/tstm_pkg.sv -----
// Package with shared types and constants for the touch sample trimmed-mean mapper.
`timescale 1ns / 1ps

package tstm_pkg;

   // Sample set and datapath widths.
   localparam int SAMPLE_TOTAL = 10;
   localparam int ADC_BITS     = 12;
   localparam int SUM_BITS     = 16;
   localparam int FILT_LSB     = 3;
   localparam int CNT_BITS     = $clog2(SAMPLE_TOTAL + 1);
   localparam int COEF_BITS    = 32;
   localparam int SCREEN_BITS  = 16;
   localparam int FRAC_BITS    = 16;
   localparam int PROD_BITS    = COEF_BITS + ADC_BITS + 1;
   localparam int ACC_BITS     = PROD_BITS + 2;
   localparam int CSR_IDX_BITS = 3;

   // Status codes carried with each result item.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ABORT = 2'd1;
   localparam logic [1:0] STATUS_NOCAL = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_XX   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_XY   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_OFFSET_X  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_YX   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_YY   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_OFFSET_Y  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAP_VALID = 3'd6;

   // Input item.
   typedef struct packed {
      logic [ADC_BITS-1:0] adc_x;
      logic [ADC_BITS-1:0] adc_y;
      logic                pen_down;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [ADC_BITS-1:0]    filtered_x;
      logic [ADC_BITS-1:0]    filtered_y;
      logic [SCREEN_BITS-1:0] screen_x;
      logic [SCREEN_BITS-1:0] screen_y;
      logic [1:0]             status;
   } rsp_type;

   // Per-axis statistics of a finished sample set.
   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [ADC_BITS-1:0] low;
      logic [ADC_BITS-1:0] high;
   } lane_snap_type;

   // Finished set handed from the lanes to the mapping pipeline.
   typedef struct packed {
      logic [1:0]    status;
      lane_snap_type x;
      lane_snap_type y;
   } set_type;

   // Calibration register file contents.
   typedef struct packed {
      logic [COEF_BITS-1:0] gain_xx;
      logic [COEF_BITS-1:0] gain_xy;
      logic [COEF_BITS-1:0] offset_x;
      logic [COEF_BITS-1:0] gain_yx;
      logic [COEF_BITS-1:0] gain_yy;
      logic [COEF_BITS-1:0] offset_y;
      logic                 map_valid;
   } coef_type;

   // Register file after reset: all coefficients zero, mapping enabled.
   localparam coef_type COEF_RESET = {{(6*COEF_BITS){1'b0}}, 1'b1};

endpackage

// ----- rtl/core/tstm_lane.sv -----
// One axis lane: running sum, minimum and maximum of the current sample set.
`timescale 1ns / 1ps

module tstm_lane
   import tstm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                first,
   input  logic                clear,
   input  logic [ADC_BITS-1:0] sample,
   output lane_snap_type       snap
);

   logic [SUM_BITS-1:0] sum_ff;
   logic [ADC_BITS-1:0] low_ff;
   logic [ADC_BITS-1:0] high_ff;

   // Statistics including the sample now offered; the first sample loads both bounds.
   always_comb begin
      snap.sum  = sum_ff + SUM_BITS'(sample);
      snap.low  = (first || (sample < low_ff))  ? sample : low_ff;
      snap.high = (first || (sample > high_ff)) ? sample : high_ff;
   end

   // Update on each accepted item; a finished or aborted set starts over.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         low_ff  <= '0;
         high_ff <= '0;
      end else if (take) begin
         if (clear) begin
            sum_ff  <= '0;
            low_ff  <= '0;
            high_ff <= '0;
         end else begin
            sum_ff  <= snap.sum;
            low_ff  <= snap.low;
            high_ff <= snap.high;
         end
      end
   end

endmodule

// ----- rtl/core/tstm_map.sv -----
// Merge stage: trimmed means of both lanes and the affine screen mapping pipeline.
`timescale 1ns / 1ps

module tstm_map
   import tstm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  coef_type coef,
   input  logic     in_valid,
   output logic     in_ready,
   input  set_type  in_set,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   // Stage 1: finished set.
   logic    v1_ff;
   set_type set1_ff;

   // Stage 2: trimmed means.
   logic                v2_ff;
   logic [1:0]          st2_ff;
   logic [ADC_BITS-1:0] fx2_ff;
   logic [ADC_BITS-1:0] fy2_ff;

   // Stage 3: products.
   logic                        v3_ff;
   logic [1:0]                  st3_ff;
   logic [ADC_BITS-1:0]         fx3_ff;
   logic [ADC_BITS-1:0]         fy3_ff;
   logic signed [PROD_BITS-1:0] pxx_ff;
   logic signed [PROD_BITS-1:0] pxy_ff;
   logic signed [PROD_BITS-1:0] pyx_ff;
   logic signed [PROD_BITS-1:0] pyy_ff;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic rdy1, rdy2, rdy3, rdy4;
   logic [SUM_BITS-1:0]         diff_x, diff_y;
   logic [ADC_BITS-1:0]         fx_in, fy_in;
   logic signed [ADC_BITS:0]    fx_s, fy_s;
   logic signed [PROD_BITS-1:0] pxx_in, pxy_in, pyx_in, pyy_in;
   logic signed [ACC_BITS-1:0]  acc_x, acc_y;
   logic [SCREEN_BITS-1:0]      scr_x_in, scr_y_in;
   rsp_type                     rsp_data_in;

   // Each stage moves on when its successor has room.
   assign rdy4     = !rsp_valid_ff || rsp_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Trimmed mean: sum less both extremes, divided by eight.
   always_comb begin
      diff_x = set1_ff.x.sum - SUM_BITS'(set1_ff.x.low) - SUM_BITS'(set1_ff.x.high);
      diff_y = set1_ff.y.sum - SUM_BITS'(set1_ff.y.low) - SUM_BITS'(set1_ff.y.high);
      fx_in  = diff_x[FILT_LSB +: ADC_BITS];
      fy_in  = diff_y[FILT_LSB +: ADC_BITS];
   end

   // Four coefficient products, each registered before the sum.
   always_comb begin
      fx_s   = $signed({1'b0, fx2_ff});
      fy_s   = $signed({1'b0, fy2_ff});
      pxx_in = $signed(coef.gain_xx) * fx_s;
      pxy_in = $signed(coef.gain_xy) * fy_s;
      pyx_in = $signed(coef.gain_yx) * fx_s;
      pyy_in = $signed(coef.gain_yy) * fy_s;
   end

   // Sum with offset, truncate the fraction and saturate to the screen range.
   always_comb begin
      acc_x = ACC_BITS'(pxx_ff) + ACC_BITS'(pxy_ff) + ACC_BITS'($signed(coef.offset_x));
      acc_y = ACC_BITS'(pyx_ff) + ACC_BITS'(pyy_ff) + ACC_BITS'($signed(coef.offset_y));
      if (acc_x < 0)
         scr_x_in = '0;
      else if (acc_x[ACC_BITS-1:FRAC_BITS+SCREEN_BITS] != '0)
         scr_x_in = '1;
      else
         scr_x_in = acc_x[FRAC_BITS +: SCREEN_BITS];
      if (acc_y < 0)
         scr_y_in = '0;
      else if (acc_y[ACC_BITS-1:FRAC_BITS+SCREEN_BITS] != '0)
         scr_y_in = '1;
      else
         scr_y_in = acc_y[FRAC_BITS +: SCREEN_BITS];
   end

   // Abort clears every field; an uncalibrated result keeps only the means.
   always_comb begin
      rsp_data_in.status = st3_ff;
      case (st3_ff)
         STATUS_OK: begin
            rsp_data_in.filtered_x = fx3_ff;
            rsp_data_in.filtered_y = fy3_ff;
            rsp_data_in.screen_x   = scr_x_in;
            rsp_data_in.screen_y   = scr_y_in;
         end
         STATUS_NOCAL: begin
            rsp_data_in.filtered_x = fx3_ff;
            rsp_data_in.filtered_y = fy3_ff;
            rsp_data_in.screen_x   = '0;
            rsp_data_in.screen_y   = '0;
         end
         default: begin
            rsp_data_in.filtered_x = '0;
            rsp_data_in.filtered_y = '0;
            rsp_data_in.screen_x   = '0;
            rsp_data_in.screen_y   = '0;
         end
      endcase
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff        <= in_valid;
         if (rdy2) v2_ff        <= v1_ff;
         if (rdy3) v3_ff        <= v2_ff;
         if (rdy4) rsp_valid_ff <= v3_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         set1_ff <= in_set;
      end
      if (rdy2) begin
         st2_ff <= set1_ff.status;
         fx2_ff <= fx_in;
         fy2_ff <= fy_in;
      end
      if (rdy3) begin
         st3_ff <= st2_ff;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
         pxx_ff <= pxx_in;
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         pyy_ff <= pyy_in;
      end
      if (rdy4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An abort result carries no coordinates and no means.
   a_abort_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_ABORT) |->
         (rsp_data_ff.filtered_x == '0) && (rsp_data_ff.filtered_y == '0) &&
         (rsp_data_ff.screen_x == '0) && (rsp_data_ff.screen_y == '0))
      else $error("abort result with nonzero fields");

   // Screen coordinates are only reported for a calibrated result.
   a_nocal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |->
         (rsp_data_ff.screen_x == '0) && (rsp_data_ff.screen_y == '0))
      else $error("coordinates reported without calibration");

   // The product stage keeps its item while it cannot advance.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy4 |=> v3_ff && $stable(st3_ff))
      else $error("stalled product stage lost its item");

endmodule

// ----- rtl/core/touch_sample_trim_mean_map_top.sv -----
// Top level of the touch sample trimmed-mean mapper: sample count, axis lanes and registers.
`timescale 1ns / 1ps

// Takes one X/Y sample pair per cycle with its pen-down flag and keeps a per-axis sum,
// minimum and maximum in two parallel lanes. The tenth sample of a set, or any sample
// with the pen up, produces one result item; other items produce none. A result
// passes four register stages: lane snapshot (loaded at the accepting edge), trimmed mean,
// coefficient multiply, then sum and saturation, whose register drives the output. One item
// is accepted per cycle while the output side takes results; a stalled output fills the
// four stages and then holds the input. Configuration registers may only be written while
// no item is in flight.

module touch_sample_trim_mean_map_top
   import tstm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]    csr_wdata
);

   coef_type            coef_ff;
   coef_type            coef_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   logic          take;
   logic          first;
   logic          last;
   logic          set_end;
   logic          pipe_ready;
   lane_snap_type snap_x;
   lane_snap_type snap_y;
   set_type       set_in;

   // Item handshake and set boundaries.
   assign req_ready = pipe_ready;
   assign take      = req_valid && pipe_ready;
   assign first     = (count_ff == '0);
   assign last      = (count_ff == CNT_BITS'(SAMPLE_TOTAL - 1));
   assign set_end   = last || !req_data.pen_down;

   // Sample count of the current set.
   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = set_end ? '0 : count_ff + 1'b1;
      end
   end

   // Register file writes.
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_XX:   coef_in.gain_xx   = csr_wdata;
            REG_GAIN_XY:   coef_in.gain_xy   = csr_wdata;
            REG_OFFSET_X:  coef_in.offset_x  = csr_wdata;
            REG_GAIN_YX:   coef_in.gain_yx   = csr_wdata;
            REG_GAIN_YY:   coef_in.gain_yy   = csr_wdata;
            REG_OFFSET_Y:  coef_in.offset_y  = csr_wdata;
            REG_MAP_VALID: coef_in.map_valid = csr_wdata[0];
            default:       coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         coef_ff  <= COEF_RESET;
      end else begin
         count_ff <= count_in;
         coef_ff  <= coef_in;
      end
   end

   // One lane per axis.
   tstm_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .first  (first),
      .clear  (set_end),
      .sample (req_data.adc_x),
      .snap   (snap_x)
   );

   tstm_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .first  (first),
      .clear  (set_end),
      .sample (req_data.adc_y),
      .snap   (snap_y)
   );

   // A finished set goes to the merge stage with its status.
   always_comb begin
      set_in.x = snap_x;
      set_in.y = snap_y;
      if (!last)
         set_in.status = STATUS_ABORT;
      else if (coef_ff.map_valid)
         set_in.status = STATUS_OK;
      else
         set_in.status = STATUS_NOCAL;
   end

   tstm_map u_map (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (take && set_end),
      .in_ready  (pipe_ready),
      .in_set    (set_in),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The count never reaches the set size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_BITS'(SAMPLE_TOTAL))
      else $error("sample count out of range");

   // The last sample of a set always restarts the count.
   a_count_wrap: assert property (@(posedge clock) disable iff (reset)
      take && last |=> count_ff == '0)
      else $error("count did not restart after a full set");

   // A sample with the pen up ends the set.
   a_pen_up_clear: assert property (@(posedge clock) disable iff (reset)
      take && !req_data.pen_down |=> count_ff == '0)
      else $error("count did not restart after pen lift");

endmodule
